[hw/rtl/udse_pkg.sv]
// Shared types, constants and microcode table for the unwind descriptor expander.
// Used by udse_emit and unwind_descriptor_sequence_expander_top; depends on nothing.
package udse_pkg;

    localparam int UPC_W  = 5;
    localparam int CNT_W  = 5;
    localparam int DATA_W = 32;
    localparam int FPS_W  = 7;

    // Program entry points and the shared finish step
    localparam logic [UPC_W-1:0] UPC_ENTRY  = 5'd0;
    localparam logic [UPC_W-1:0] UPC_FINISH = 5'd8;
    localparam logic [UPC_W-1:0] UPC_EXIT   = 5'd9;

    // Result step codes
    localparam logic [1:0] STEP_VALID    = 2'd0;
    localparam logic [1:0] STEP_FP_SETUP = 2'd1;
    localparam logic [1:0] STEP_RESTORED = 2'd2;

    // Condition under which a step runs; a false condition skips to the next address
    typedef enum logic [3:0] {
        C_ALWAYS    = 4'd0,
        C_RP        = 4'd1,
        C_NGR       = 4'd2,
        C_NGR_LARGE = 4'd3,
        C_NGR_SMALL = 4'd4,
        C_BUMP_ONLY = 4'd5,
        C_NSP       = 4'd6,
        C_ANY       = 4'd7
    } cond_t;

    // Repeat count source
    typedef enum logic [1:0] {
        R_ONE    = 2'd0,
        R_TWO    = 2'd1,
        R_NFP    = 2'd2,
        R_NGR_M1 = 2'd3
    } rep_t;

    typedef enum logic [1:0] {
        K_EMIT   = 2'd0,
        K_INSERT = 2'd1,
        K_FINISH = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        CD_VALID    = 2'd0,
        CD_FP_SETUP = 2'd1,
        CD_RESTORED = 2'd2,
        CD_REG      = 2'd3
    } code_sel_t;

    typedef enum logic [3:0] {
        SZ_ZERO    = 4'd0,
        SZ_REG     = 4'd1,
        SZ_ADD8    = 4'd2,
        SZ_ADDBUMP = 4'd3,
        SZ_FRAME   = 4'd4,
        SZ_BUMP    = 4'd5,
        SZ_FPS     = 4'd6,
        SZ_FPS8    = 4'd7,
        SZ_SUB8    = 4'd8
    } size_sel_t;

    // Which value the deferred branch-return slot takes
    typedef enum logic [1:0] {
        P_NONE     = 2'd0,
        P_OLD_SIZE = 2'd1,
        P_OLD_BOTH = 2'd2,
        P_EMIT     = 2'd3
    } prev_sel_t;

    typedef struct packed {
        cond_t            cond;
        rep_t             rep;
        kind_t            kind;
        code_sel_t        code_sel;
        size_sel_t        size_sel;
        logic             wr;
        prev_sel_t        prev_sel;
        logic [UPC_W-1:0] next;
    } ucw_t;

    // Request from the sequencer to the output stage
    typedef struct packed {
        logic              push;
        logic              insert;
        logic              finish;
        logic [1:0]        code;
        logic [DATA_W-1:0] bytes;
    } emit_req_t;

    function automatic ucw_t uop(cond_t c, rep_t r, kind_t k, code_sel_t cs,
                                 size_sel_t ss, logic wr, prev_sel_t ps,
                                 logic [UPC_W-1:0] nx);
        ucw_t w;
        w.cond     = c;
        w.rep      = r;
        w.kind     = k;
        w.code_sel = cs;
        w.size_sel = ss;
        w.wr       = wr;
        w.prev_sel = ps;
        w.next     = nx;
        return w;
    endfunction

    // Control store: entry program at 0, finish at 8, exit program from 9
    function automatic ucw_t ucode_rom(logic [UPC_W-1:0] addr);
        ucw_t w;
        unique case (addr)
            // entry: return pointer store
            5'd0:  w = uop(C_RP, R_ONE, K_EMIT, CD_VALID, SZ_ZERO, 1'b0, P_NONE, 5'd1);
            // entry: floating spills, eight bytes each
            5'd1:  w = uop(C_ALWAYS, R_NFP, K_EMIT, CD_VALID, SZ_ADD8, 1'b1, P_NONE, 5'd2);
            // entry: first general spill carries the frame bump
            5'd2:  w = uop(C_NGR, R_ONE, K_EMIT, CD_VALID, SZ_ADDBUMP, 1'b1, P_NONE, 5'd3);
            // entry: large frame pointer setup
            5'd3:  w = uop(C_NGR_LARGE, R_TWO, K_EMIT, CD_FP_SETUP, SZ_REG, 1'b0,
                           P_NONE, 5'd4);
            5'd4:  w = uop(C_NGR_LARGE, R_ONE, K_EMIT, CD_FP_SETUP, SZ_FRAME, 1'b1,
                           P_NONE, 5'd5);
            // entry: remaining general spills
            5'd5:  w = uop(C_NGR, R_NGR_M1, K_EMIT, CD_REG, SZ_REG, 1'b0, P_NONE, 5'd6);
            // entry: bare frame bump
            5'd6:  w = uop(C_BUMP_ONLY, R_ONE, K_EMIT, CD_VALID, SZ_BUMP, 1'b0,
                           P_NONE, 5'd7);
            // entry: space register pair
            5'd7:  w = uop(C_NSP, R_TWO, K_EMIT, CD_REG, SZ_REG, 1'b0, P_NONE, UPC_FINISH);
            5'd8:  w = uop(C_ALWAYS, R_ONE, K_FINISH, CD_VALID, SZ_ZERO, 1'b0,
                           P_NONE, UPC_FINISH);
            // exit: return pointer load
            5'd9:  w = uop(C_RP, R_ONE, K_EMIT, CD_VALID, SZ_REG, 1'b0, P_NONE, 5'd10);
            // exit: space register pair
            5'd10: w = uop(C_NSP, R_TWO, K_EMIT, CD_VALID, SZ_REG, 1'b0, P_NONE, 5'd11);
            // exit: general restores before the last one
            5'd11: w = uop(C_NGR, R_NGR_M1, K_EMIT, CD_VALID, SZ_REG, 1'b0, P_NONE, 5'd12);
            // exit: last general restore pops the bump
            5'd12: w = uop(C_NGR_SMALL, R_ONE, K_EMIT, CD_RESTORED, SZ_FPS, 1'b1,
                           P_OLD_SIZE, 5'd13);
            5'd13: w = uop(C_NGR_LARGE, R_ONE, K_EMIT, CD_FP_SETUP, SZ_FPS8, 1'b0,
                           P_EMIT, 5'd14);
            5'd14: w = uop(C_NGR_LARGE, R_ONE, K_EMIT, CD_RESTORED, SZ_FPS, 1'b1,
                           P_NONE, 5'd15);
            // exit: bare frame pop
            5'd15: w = uop(C_BUMP_ONLY, R_ONE, K_EMIT, CD_RESTORED, SZ_FPS, 1'b1,
                           P_NONE, 5'd16);
            // exit: floating restores
            5'd16: w = uop(C_ALWAYS, R_NFP, K_EMIT, CD_RESTORED, SZ_SUB8, 1'b1,
                           P_OLD_BOTH, 5'd17);
            // exit: branch-return slot ahead of the held final item
            5'd17: w = uop(C_ANY, R_ONE, K_INSERT, CD_VALID, SZ_ZERO, 1'b0,
                           P_NONE, UPC_FINISH);
            // exit: nothing popped, plain return pair
            5'd18: w = uop(C_ALWAYS, R_TWO, K_EMIT, CD_RESTORED, SZ_ZERO, 1'b0,
                           P_NONE, UPC_FINISH);
            default: w = uop(C_ALWAYS, R_ONE, K_FINISH, CD_VALID, SZ_ZERO, 1'b0,
                             P_NONE, UPC_FINISH);
        endcase
        return w;
    endfunction

    function automatic logic [CNT_W-1:0] rep_count(rep_t r, logic [3:0] nfp,
                                                   logic [4:0] ngr);
        logic [CNT_W-1:0] n;
        unique case (r)
            R_ONE:    n = 5'd1;
            R_TWO:    n = 5'd2;
            R_NFP:    n = {1'b0, nfp};
            R_NGR_M1: n = ngr - 5'd1;
        endcase
        return n;
    endfunction

endpackage

[hw/rtl/udse_emit.sv]
// Output stage: holds the most recent item back one slot so the branch-return
// slot can go ahead of it, and registers the result channel. Depends on udse_pkg.
module udse_emit (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  udse_pkg::emit_req_t   req,
    output logic                  emit_rdy,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [1:0]            m_step_code,
    output logic signed [31:0]    m_frame_bytes,
    output logic                  m_last_in_run
);
    import udse_pkg::*;

    logic              pend_valid_reg, pend_valid_next;
    logic [1:0]        pend_code_reg, pend_code_next;
    logic [DATA_W-1:0] pend_bytes_reg, pend_bytes_next;
    logic              m_valid_reg, m_valid_next;
    logic [1:0]        out_code_reg, out_code_next;
    logic [DATA_W-1:0] out_bytes_reg, out_bytes_next;
    logic              out_last_reg, out_last_next;

    // Output register is free when empty or being taken this cycle
    assign emit_rdy = !m_valid_reg || m_ready;

    // Move the held item or the inserted slot into the output register
    always_comb begin
        pend_valid_next = pend_valid_reg;
        pend_code_next  = pend_code_reg;
        pend_bytes_next = pend_bytes_reg;
        m_valid_next    = m_valid_reg;
        out_code_next   = out_code_reg;
        out_bytes_next  = out_bytes_reg;
        out_last_next   = out_last_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (req.push) begin
            if (pend_valid_reg) begin
                m_valid_next   = 1'b1;
                out_code_next  = pend_code_reg;
                out_bytes_next = pend_bytes_reg;
                out_last_next  = 1'b0;
            end
            pend_valid_next = 1'b1;
            pend_code_next  = req.code;
            pend_bytes_next = req.bytes;
        end else if (req.insert) begin
            m_valid_next   = 1'b1;
            out_code_next  = req.code;
            out_bytes_next = req.bytes;
            out_last_next  = 1'b0;
        end else if (req.finish && pend_valid_reg) begin
            m_valid_next    = 1'b1;
            out_code_next   = pend_code_reg;
            out_bytes_next  = pend_bytes_reg;
            out_last_next   = 1'b1;
            pend_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            pend_valid_reg <= pend_valid_next;
            m_valid_reg    <= m_valid_next;
        end
        pend_code_reg  <= pend_code_next;
        pend_bytes_reg <= pend_bytes_next;
        out_code_reg   <= out_code_next;
        out_bytes_reg  <= out_bytes_next;
        out_last_reg   <= out_last_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_step_code   = out_code_reg;
    assign m_frame_bytes = $signed(out_bytes_reg);
    assign m_last_in_run = out_last_reg;

endmodule

[hw/rtl/unwind_descriptor_sequence_expander_top.sv]
// Unwind descriptor sequence expander: decode, microcode sequencer and datapath.
// Depends on udse_pkg and udse_emit.
//
// One descriptor (two words plus an entry/exit select) is taken when s_ready is
// high, and s_ready stays low until its run is finished. The run is produced by
// a 19-word microcode program, one control word per step, stepping one result
// per cycle while the output stage can take it; a step whose condition or repeat
// count is zero is skipped, and a finish step closes the run. The last result of
// a run is marked by m_last_in_run; an empty entry sequence yields no result at
// all.
module unwind_descriptor_sequence_expander_top (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [31:0]         s_descriptor_word1,
    input  logic [31:0]         s_descriptor_word2,
    input  logic                s_action,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [1:0]          m_step_code,
    output logic signed [31:0]  m_frame_bytes,
    output logic                m_last_in_run
);
    import udse_pkg::*;

    logic              busy_reg, busy_next;
    logic [UPC_W-1:0]  pc_reg, pc_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [1:0]        code_reg, code_next;
    logic [DATA_W-1:0] size_reg, size_next;
    logic [1:0]        prev_code_reg, prev_code_next;
    logic [DATA_W-1:0] prev_size_reg, prev_size_next;
    logic [DATA_W-1:0] frame_reg, frame_next;
    logic [FPS_W-1:0]  fps_reg, fps_next;
    logic [DATA_W-1:0] bump_reg, bump_next;
    logic [3:0]        nfp_reg, nfp_next;
    logic [4:0]        ngr_reg, ngr_next;
    logic              nsp_reg, nsp_next;
    logic              rp_reg, rp_next;
    logic              large_reg, large_next;

    ucw_t              uw;
    ucw_t              uw_seq;
    ucw_t              uw_jmp;
    ucw_t              uw_start;
    logic [UPC_W-1:0]  pc_seq;
    logic [UPC_W-1:0]  start_pc;
    logic              cond_ok;
    logic              any_pop;
    logic [1:0]        code_val;
    logic [DATA_W-1:0] size_val;
    logic [DATA_W-1:0] fps_ext;
    logic [DATA_W-1:0] in_frame;
    logic [FPS_W-1:0]  in_fps;
    logic              emit_rdy;
    emit_req_t         req;

    // Decode the incoming descriptor
    assign in_frame = {s_descriptor_word2[26:0], 3'b000};
    assign in_fps   = {s_descriptor_word1[24:21], 3'b000};
    assign start_pc = s_action ? UPC_EXIT : UPC_ENTRY;
    assign uw_start = ucode_rom(start_pc);

    // Fetch the current control word and both possible successors
    assign uw     = ucode_rom(pc_reg);
    assign pc_seq = pc_reg + 5'd1;
    assign uw_seq = ucode_rom(pc_seq);
    assign uw_jmp = ucode_rom(uw.next);

    assign fps_ext = {{(DATA_W-FPS_W){1'b0}}, fps_reg};
    assign any_pop = (ngr_reg != 5'd0) || (bump_reg != '0) || (nfp_reg != 4'd0);

    // Evaluate the step condition
    always_comb begin
        case (uw.cond)
            C_ALWAYS:    cond_ok = 1'b1;
            C_RP:        cond_ok = rp_reg;
            C_NGR:       cond_ok = ngr_reg != 5'd0;
            C_NGR_LARGE: cond_ok = (ngr_reg != 5'd0) && large_reg;
            C_NGR_SMALL: cond_ok = (ngr_reg != 5'd0) && !large_reg;
            C_BUMP_ONLY: cond_ok = (ngr_reg == 5'd0) && (bump_reg != '0);
            C_NSP:       cond_ok = nsp_reg;
            C_ANY:       cond_ok = any_pop;
            default:     cond_ok = 1'b0;
        endcase
    end

    // Select the code and byte count of this step
    always_comb begin
        unique case (uw.code_sel)
            CD_VALID:    code_val = STEP_VALID;
            CD_FP_SETUP: code_val = STEP_FP_SETUP;
            CD_RESTORED: code_val = STEP_RESTORED;
            CD_REG:      code_val = code_reg;
        endcase
        case (uw.size_sel)
            SZ_ZERO:    size_val = '0;
            SZ_REG:     size_val = size_reg;
            SZ_ADD8:    size_val = size_reg + 32'd8;
            SZ_ADDBUMP: size_val = size_reg + (large_reg ? 32'd8 : bump_reg);
            SZ_FRAME:   size_val = frame_reg;
            SZ_BUMP:    size_val = bump_reg;
            SZ_FPS:     size_val = fps_ext;
            SZ_FPS8:    size_val = fps_ext + 32'd8;
            SZ_SUB8:    size_val = size_reg - 32'd8;
            default:    size_val = '0;
        endcase
    end

    // Sequencer: accept, skip, repeat, jump and finish
    always_comb begin
        busy_next      = busy_reg;
        pc_next        = pc_reg;
        cnt_next       = cnt_reg;
        code_next      = code_reg;
        size_next      = size_reg;
        prev_code_next = prev_code_reg;
        prev_size_next = prev_size_reg;
        frame_next     = frame_reg;
        fps_next       = fps_reg;
        bump_next      = bump_reg;
        nfp_next       = nfp_reg;
        ngr_next       = ngr_reg;
        nsp_next       = nsp_reg;
        rp_next        = rp_reg;
        large_next     = large_reg;
        req            = '0;
        if (!busy_reg) begin
            if (s_valid) begin
                busy_next      = 1'b1;
                pc_next        = start_pc;
                cnt_next       = rep_count(uw_start.rep, s_descriptor_word1[24:21],
                                           s_descriptor_word1[20:16]);
                frame_next     = in_frame;
                fps_next       = in_fps;
                bump_next      = in_frame - {{(DATA_W-FPS_W){1'b0}}, in_fps};
                nfp_next       = s_descriptor_word1[24:21];
                ngr_next       = s_descriptor_word1[20:16];
                nsp_next       = |s_descriptor_word1[26:25];
                rp_next        = s_descriptor_word1[3];
                large_next     = s_descriptor_word2[29];
                code_next      = STEP_VALID;
                size_next      = s_action ? in_frame : '0;
                prev_code_next = STEP_VALID;
                prev_size_next = in_frame;
            end
        end else begin
            priority if (uw.kind == K_FINISH) begin
                if (emit_rdy) begin
                    req.finish = 1'b1;
                    busy_next  = 1'b0;
                end
            end else if (!cond_ok || cnt_reg == '0) begin
                pc_next  = pc_seq;
                cnt_next = rep_count(uw_seq.rep, nfp_reg, ngr_reg);
            end else if (emit_rdy) begin
                if (uw.kind == K_INSERT) begin
                    req.insert = 1'b1;
                    req.code   = prev_code_reg;
                    req.bytes  = prev_size_reg;
                end else begin
                    req.push  = 1'b1;
                    req.code  = code_val;
                    req.bytes = size_val;
                    if (uw.wr) begin
                        code_next = code_val;
                        size_next = size_val;
                    end
                    unique case (uw.prev_sel)
                        P_NONE: begin
                        end
                        P_OLD_SIZE: begin
                            prev_size_next = size_reg;
                        end
                        P_OLD_BOTH: begin
                            prev_code_next = code_reg;
                            prev_size_next = size_reg;
                        end
                        P_EMIT: begin
                            prev_code_next = code_val;
                            prev_size_next = size_val;
                        end
                    endcase
                end
                if (cnt_reg == 5'd1) begin
                    pc_next  = uw.next;
                    cnt_next = rep_count(uw_jmp.rep, nfp_reg, ngr_reg);
                end else begin
                    cnt_next = cnt_reg - 5'd1;
                end
            end else begin
                // hold the step while the output stage is full
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            pc_reg   <= UPC_FINISH;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            pc_reg   <= pc_next;
            cnt_reg  <= cnt_next;
        end
        code_reg      <= code_next;
        size_reg      <= size_next;
        prev_code_reg <= prev_code_next;
        prev_size_reg <= prev_size_next;
        frame_reg     <= frame_next;
        fps_reg       <= fps_next;
        bump_reg      <= bump_next;
        nfp_reg       <= nfp_next;
        ngr_reg       <= ngr_next;
        nsp_reg       <= nsp_next;
        rp_reg        <= rp_next;
        large_reg     <= large_next;
    end

    assign s_ready = !busy_reg;

    udse_emit u_emit (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .req           (req),
        .emit_rdy      (emit_rdy),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_step_code   (m_step_code),
        .m_frame_bytes (m_frame_bytes),
        .m_last_in_run (m_last_in_run)
    );

endmodule
